// ===== src/scc_pkg.sv =====
// Shared constants, types and codes for the spaced tap code correlator.
package scc_pkg;

    localparam int CODE_TAPS   = 32;
    localparam int MAX_SPACING = 64;
    localparam int DELAY_DEPTH = (CODE_TAPS - 1) * MAX_SPACING + 1;

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
    localparam int SP_W   = $clog2(MAX_SPACING + 1);
    localparam int CNT_W  = (CODE_TAPS > 2) ? $clog2(CODE_TAPS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 22;
    localparam int IDX_W    = 32;
    localparam int SPR_W    = 7;
    localparam int STEP_W   = 10;
    localparam int CODE_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SPR_W-1:0]  SPACING_RESET = 7'd32;
    localparam logic [STEP_W-1:0] STEP_RESET    = 10'd20;
    localparam logic [CODE_W-1:0] CODE_RESET    = 32'h1738_B6BF;

    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic add;
        logic chip;
    } t_acc_ctl;

endpackage

// ===== src/scc_delay_mem.sv =====
// Sample delay line: one write port, one registered read port.
module scc_delay_mem
    import scc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic signed [SAMPLE_W-1:0] o_rd_data
);

    logic signed [SAMPLE_W-1:0] r_mem [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/scc_accum.sv =====
// Shared add/subtract accumulator for the tap sum.
module scc_accum
    import scc_pkg::*;
(
    input  logic                       i_clk,
    input  t_acc_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_data,
    output logic signed [CORR_W-1:0]   o_acc
);

    logic signed [CORR_W-1:0] r_acc;
    logic signed [CORR_W-1:0] n_acc;
    logic signed [CORR_W-1:0] w_ext;

    assign w_ext = CORR_W'(i_data);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.add) begin
            n_acc = i_ctl.chip ? (r_acc + w_ext) : (r_acc - w_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== src/spaced_tap_code_correlator.sv =====
// Top level: sequencer, counters, config registers and output register.
// An emitting item is followed by 32 tap reads, the registered memory read and a load
// into the output register; the load waits while the previous result is still unaccepted.
// Throughput: one item per cycle when no result is due; an emitting item holds input off
// until its result is loaded, since the single memory read port walks the 32 taps.
// Reset (sync, active low) clears counters and phase, sets config defaults, not the memory.
module spaced_tap_code_correlator
    import scc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_first_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [CORR_W-1:0]   o_correlation,
    output logic [IDX_W-1:0]           o_window_start,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_state r_state, n_state;

    logic [SPR_W-1:0]  r_cfg_spacing;
    logic [STEP_W-1:0] r_cfg_step;
    logic [CODE_W-1:0] r_cfg_code;

    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0]  r_seen, n_seen;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [STEP_W-1:0] r_phase, n_phase;

    logic [SP_W-1:0]   r_sp, n_sp;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_chip, n_rd_chip;
    logic [IDX_W-1:0]  r_ws, n_ws;

    logic                     r_out_valid, n_out_valid;
    logic signed [CORR_W-1:0] r_corr;
    logic [IDX_W-1:0]         r_ws_out;
    logic                     w_load_out;

    logic                       w_accept;
    logic                       w_emit;
    logic                       w_rd_en;
    logic [SP_W-1:0]            w_sp;
    logic [STEP_W-1:0]          w_step;
    logic [FILL_W-1:0]          w_span;
    logic [IDX_W-1:0]           w_seen_base;
    logic [FILL_W-1:0]          w_fill_base;
    logic [STEP_W-1:0]          w_phase_base;
    logic [STEP_W:0]            w_phase_inc;
    logic                       w_chip;
    t_acc_ctl                   w_acc_ctl;
    logic signed [SAMPLE_W-1:0] w_rd_data;
    logic signed [CORR_W-1:0]   w_acc;

    // Effective register values after range clamping.
    always_comb begin
        if (r_cfg_spacing == '0) begin
            w_sp = SP_W'(1);
        end else if (32'(r_cfg_spacing) > MAX_SPACING) begin
            w_sp = SP_W'(MAX_SPACING);
        end else begin
            w_sp = SP_W'(r_cfg_spacing);
        end
        w_step = (r_cfg_step == '0) ? STEP_W'(1) : r_cfg_step;
    end

    assign w_span = FILL_W'((CODE_TAPS - 1) * 32'(w_sp) + 1);

    always_comb begin
        if (32'(r_k) < 32) begin
            w_chip = r_cfg_code[5'(r_k)];
        end else begin
            w_chip = 1'b0;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_seen_base  = i_first_sample ? '0 : r_seen;
        w_fill_base  = i_first_sample ? '0 : r_fill;
        w_phase_base = i_first_sample ? '0 : r_phase;
        w_phase_inc  = {1'b0, w_phase_base} + 1'b1;

        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_seen      = r_seen;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_sp        = r_sp;
        n_addr      = r_addr;
        n_k         = r_k;
        n_ws        = r_ws;
        n_rd_vld    = 1'b0;
        n_rd_chip   = r_rd_chip;
        n_out_valid = r_out_valid;
        w_emit      = 1'b0;
        w_rd_en     = 1'b0;
        w_load_out  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_wr_ptr = (32'(r_wr_ptr) + 1 >= DELAY_DEPTH) ? '0 : r_wr_ptr + 1'b1;
                    n_seen   = w_seen_base + 1'b1;
                    n_fill   = (32'(w_fill_base) < DELAY_DEPTH) ? w_fill_base + 1'b1
                                                                : w_fill_base;
                    n_phase  = w_phase_base;
                    if (n_fill >= w_span) begin
                        w_emit  = (w_phase_base == '0);
                        n_phase = (w_phase_inc >= {1'b0, w_step}) ? '0
                                                                  : w_phase_inc[STEP_W-1:0];
                    end
                    if (w_emit) begin
                        n_sp    = w_sp;
                        n_addr  = r_wr_ptr;
                        n_k     = '0;
                        n_ws    = n_seen - IDX_W'(w_span);
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // Walk back one symbol per cycle from the newest sample.
                w_rd_en   = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_chip = w_chip;
                if (r_addr < ADDR_W'(r_sp)) begin
                    n_addr = r_addr + ADDR_W'(DELAY_DEPTH) - ADDR_W'(r_sp);
                end else begin
                    n_addr = r_addr - ADDR_W'(r_sp);
                end
                n_k = r_k + 1'b1;
                if (32'(r_k) == CODE_TAPS - 1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_seen      <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_seen      <= n_seen;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp      <= n_sp;
        r_addr    <= n_addr;
        r_ws      <= n_ws;
        r_rd_chip <= n_rd_chip;
        if (w_load_out) begin
            r_corr   <= w_acc;
            r_ws_out <= r_ws;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_spacing <= SPACING_RESET;
            r_cfg_step    <= STEP_RESET;
            r_cfg_code    <= CODE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SPACING: r_cfg_spacing <= i_cfg_data[SPR_W-1:0];
                CFG_STEP:    r_cfg_step    <= i_cfg_data[STEP_W-1:0];
                CFG_CODE:    r_cfg_code    <= i_cfg_data[CODE_W-1:0];
                default:     ;
            endcase
        end
    end

    scc_delay_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_acc_ctl.clr  = w_emit;
    assign w_acc_ctl.add  = r_rd_vld;
    assign w_acc_ctl.chip = r_rd_chip;

    scc_accum u_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_acc_ctl),
        .i_data (w_rd_data),
        .o_acc  (w_acc)
    );

    assign o_out_valid    = r_out_valid;
    assign o_correlation  = r_corr;
    assign o_window_start = r_ws_out;

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result loaded outside the finish state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DELAY_DEPTH)
        else $error("fill count beyond delay depth");

    a_tap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_k != '0) |-> r_k == CNT_W'($past(r_k) + 1'b1))
        else $error("tap counter skipped");
`endif

endmodule
